// ===== design/rame_pkg.sv =====
// Shared types and constants for the accumulator machine execute block.
`default_nettype none

package rame_pkg;

  localparam int unsigned WORD_BITS     = 32;
  localparam int unsigned IP_BITS       = 16;
  localparam int unsigned MEM_WORDS_DEF = 64;
  localparam int unsigned CMD_BITS      = 4;
  localparam int unsigned MODE_BITS     = 2;
  localparam int unsigned ERR_BITS      = 3;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [IP_BITS-1:0]   ip_t;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_JUMP  = 4'd0,
    CMD_JZERO = 4'd1,
    CMD_JGTZ  = 4'd2,
    CMD_LOAD  = 4'd3,
    CMD_STORE = 4'd4,
    CMD_ADD   = 4'd5,
    CMD_SUB   = 4'd6,
    CMD_MULT  = 4'd7,
    CMD_DIV   = 4'd8,
    CMD_READ  = 4'd9,
    CMD_WRITE = 4'd10,
    CMD_HALT  = 4'd11
  } cmd_e;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_DIRECT    = 2'd0,
    MODE_INDIRECT  = 2'd1,
    MODE_IMMEDIATE = 2'd2
  } mode_e;

  typedef enum logic [ERR_BITS-1:0] {
    ERR_NONE      = 3'd0,
    ERR_OPCODE    = 3'd1,
    ERR_IMM_STORE = 3'd2,
    ERR_IMM_READ  = 3'd3,
    ERR_DIV_ZERO  = 3'd4,
    ERR_RANGE     = 3'd5
  } err_e;

endpackage

`default_nettype wire

// ===== design/rame_if.sv =====
// Instruction and result channel interfaces (valid/ready with payload).
`default_nettype none

interface rame_in_if;
  logic                           valid;
  logic                           ready;
  logic [rame_pkg::CMD_BITS-1:0]  cmd;
  logic [rame_pkg::MODE_BITS-1:0] mode;
  rame_pkg::word_t                argument;
  rame_pkg::word_t                read_value;

  modport source (output valid, cmd, mode, argument, read_value, input ready);
  modport sink   (input valid, cmd, mode, argument, read_value, output ready);
endinterface

interface rame_out_if;
  logic                          valid;
  logic                          ready;
  rame_pkg::ip_t                 next_ip;
  logic                          write_valid;
  rame_pkg::word_t               write_value;
  logic                          halted;
  logic [rame_pkg::ERR_BITS-1:0] error_code;

  modport source (output valid, next_ip, write_valid, write_value, halted, error_code,
                  input ready);
  modport sink   (input valid, next_ip, write_valid, write_value, halted, error_code,
                  output ready);
endinterface

`default_nettype wire

// ===== design/random_access_machine_execute_top.sv =====
// Top level: accumulator machine sequencer, register memory and result register.
`default_nettype none

// Executes one accumulator-machine instruction per input transaction and
// returns one result transaction (next pointer, optional WRITE value, halted
// flag, error code). After reset the register memory is swept to zero, one
// cell per cycle, while in_i.ready stays low. The block takes one
// instruction at a time: in_i.ready is high only when the sequencer is
// idle. From acceptance to the result: a stopped machine, jumps, HALT and
// decode errors go from decode straight to the done state; immediate
// operands add an execute step; direct memory operands first go through
// the read and data states on the single registered read port; indirect
// operands pass through them twice, once for the pointer cell. DIV then runs the
// bit-serial divider (one quotient bit per cycle). MULT is a combinational
// 32x32 multiply written straight into the accumulator. A new instruction may
// be accepted while the previous result still waits on out_o.ready.
module random_access_machine_execute_top #(
  parameter int unsigned MEM_WORDS = rame_pkg::MEM_WORDS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  rame_in_if.sink           in_i,
  rame_out_if.source        out_o
);

  localparam int unsigned W  = rame_pkg::WORD_BITS;
  localparam int unsigned IP = rame_pkg::IP_BITS;
  localparam int unsigned AW = $clog2(MEM_WORDS);
  localparam rame_pkg::word_t MemWordsW = rame_pkg::word_t'(MEM_WORDS);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_RD,
    S_DATA,
    S_EXEC,
    S_DIV,
    S_DONE
  } state_e;

  typedef struct packed {
    rame_pkg::ip_t   ip;
    logic            wv;
    rame_pkg::word_t wval;
    logic            halted;
    rame_pkg::err_e  err;
  } res_t;

  function automatic logic in_range(rame_pkg::word_t a);
    return ~a[W-1] && (a < MemWordsW);
  endfunction

  function automatic res_t mk_res(rame_pkg::ip_t nip, logic wv, rame_pkg::word_t wval,
                                  logic halt, rame_pkg::err_e err);
    res_t r;
    r.ip     = nip;
    r.wv     = wv;
    r.wval   = wval;
    r.halted = halt;
    r.err    = err;
    return r;
  endfunction

  // control state
  state_e                         state_q;
  logic [AW-1:0]                  clr_cnt_q;
  rame_pkg::ip_t                  ip_q;
  logic                           stopped_q;
  rame_pkg::word_t                acc_q;
  logic                           out_valid_q;
  logic                           indir_q;

  // instruction and payload
  logic [rame_pkg::CMD_BITS-1:0]  cmd_q;
  logic [rame_pkg::MODE_BITS-1:0] mode_q;
  rame_pkg::word_t                arg_q;
  rame_pkg::word_t                rv_q;
  logic [AW-1:0]                  addr_q;
  rame_pkg::word_t                opnd_q;
  res_t                           res_q;
  res_t                           out_q;

  // register memory, cell 0 mirrors acc_q
  rame_pkg::word_t                mem_q [MEM_WORDS];
  rame_pkg::word_t                rdata_q;

  logic                           wr_en;
  logic [AW-1:0]                  wr_addr;
  rame_pkg::word_t                wr_data;

  rame_pkg::ip_t                  ip_inc;
  logic                           acc_zero;
  logic                           take;
  logic                           jump_ok;
  logic                           div_start;
  logic                           div_done;
  rame_pkg::word_t                quotient;
  logic                           out_load;

  assign ip_inc   = rame_pkg::ip_t'(ip_q + 1'b1);
  assign acc_zero = (acc_q == '0);
  assign take     = (cmd_q == rame_pkg::CMD_JUMP)
                 || ((cmd_q == rame_pkg::CMD_JZERO) && acc_zero)
                 || ((cmd_q == rame_pkg::CMD_JGTZ) && ~acc_q[W-1] && ~acc_zero);
  assign jump_ok  = (arg_q[W-1:IP] == '0);

  assign div_start = (state_q == S_EXEC) && (cmd_q == rame_pkg::CMD_DIV) && (opnd_q != '0);
  assign out_load  = (state_q == S_DONE) && (~out_valid_q || out_o.ready);

  rame_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (acc_q),
    .divisor_i  (opnd_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // memory write port: clear sweep, accumulator updates, STORE/READ
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = addr_q;
    wr_data = acc_q;
    case (state_q)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_cnt_q;
        wr_data = '0;
      end
      S_EXEC: begin
        case (cmd_q)
          rame_pkg::CMD_LOAD: begin
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_data = opnd_q;
          end
          rame_pkg::CMD_ADD: begin
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_data = rame_pkg::word_t'(acc_q + opnd_q);
          end
          rame_pkg::CMD_SUB: begin
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_data = rame_pkg::word_t'(acc_q - opnd_q);
          end
          rame_pkg::CMD_MULT: begin
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_data = rame_pkg::word_t'(acc_q * opnd_q);
          end
          rame_pkg::CMD_STORE: begin
            wr_en   = 1'b1;
            wr_data = acc_q;
          end
          rame_pkg::CMD_READ: begin
            wr_en   = 1'b1;
            wr_data = rv_q;
          end
          default: begin
            wr_en = 1'b0;
          end
        endcase
      end
      S_DIV: begin
        wr_en   = div_done;
        wr_addr = '0;
        wr_data = quotient;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rdata_q <= mem_q[addr_q];
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_cnt_q   <= '0;
      ip_q        <= '0;
      stopped_q   <= 1'b0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
      indir_q     <= 1'b0;
    end else begin
      if (wr_en && (wr_addr == '0)) begin
        acc_q <= wr_data;
      end
      if (out_o.valid && out_o.ready && !out_load) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + 1'b1;
          if (clr_cnt_q == AW'(MEM_WORDS - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_i.valid) begin
            state_q <= S_DECODE;
          end
        end
        S_DECODE: begin
          state_q <= S_DONE;
          if (stopped_q) begin
            res_q <= mk_res(ip_q, 1'b0, '0, 1'b1, rame_pkg::ERR_NONE);
          end else begin
            case (cmd_q)
              rame_pkg::CMD_JUMP, rame_pkg::CMD_JZERO, rame_pkg::CMD_JGTZ: begin
                if (!take) begin
                  res_q <= mk_res(ip_inc, 1'b0, '0, 1'b0, rame_pkg::ERR_NONE);
                end else if (jump_ok) begin
                  res_q <= mk_res(arg_q[IP-1:0], 1'b0, '0, 1'b0, rame_pkg::ERR_NONE);
                end else begin
                  res_q <= mk_res(ip_q, 1'b0, '0, 1'b1, rame_pkg::ERR_RANGE);
                end
              end
              rame_pkg::CMD_HALT: begin
                res_q <= mk_res(ip_q, 1'b0, '0, 1'b1, rame_pkg::ERR_NONE);
              end
              rame_pkg::CMD_LOAD, rame_pkg::CMD_STORE, rame_pkg::CMD_ADD,
              rame_pkg::CMD_SUB, rame_pkg::CMD_MULT, rame_pkg::CMD_DIV,
              rame_pkg::CMD_READ, rame_pkg::CMD_WRITE: begin
                if (mode_q == rame_pkg::MODE_IMMEDIATE) begin
                  if (cmd_q == rame_pkg::CMD_STORE) begin
                    res_q <= mk_res(ip_q, 1'b0, '0, 1'b1, rame_pkg::ERR_IMM_STORE);
                  end else if (cmd_q == rame_pkg::CMD_READ) begin
                    res_q <= mk_res(ip_q, 1'b0, '0, 1'b1, rame_pkg::ERR_IMM_READ);
                  end else begin
                    opnd_q  <= arg_q;
                    state_q <= S_EXEC;
                  end
                end else if (!in_range(arg_q)) begin
                  res_q <= mk_res(ip_q, 1'b0, '0, 1'b1, rame_pkg::ERR_RANGE);
                end else begin
                  addr_q  <= arg_q[AW-1:0];
                  indir_q <= (mode_q == rame_pkg::MODE_INDIRECT);
                  state_q <= S_RD;
                end
              end
              default: begin
                res_q <= mk_res(ip_q, 1'b0, '0, 1'b1, rame_pkg::ERR_OPCODE);
              end
            endcase
          end
        end
        S_RD: begin
          state_q <= S_DATA;
        end
        S_DATA: begin
          if (indir_q) begin
            // pointer cell read; follow it once more
            if (in_range(rdata_q)) begin
              addr_q  <= rdata_q[AW-1:0];
              indir_q <= 1'b0;
              state_q <= S_RD;
            end else begin
              res_q   <= mk_res(ip_q, 1'b0, '0, 1'b1, rame_pkg::ERR_RANGE);
              state_q <= S_DONE;
            end
          end else begin
            opnd_q  <= rdata_q;
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_q <= S_DONE;
          case (cmd_q)
            rame_pkg::CMD_DIV: begin
              if (opnd_q == '0) begin
                res_q <= mk_res(ip_q, 1'b0, '0, 1'b1, rame_pkg::ERR_DIV_ZERO);
              end else begin
                state_q <= S_DIV;
              end
            end
            rame_pkg::CMD_WRITE: begin
              res_q <= mk_res(ip_inc, 1'b1, opnd_q, 1'b0, rame_pkg::ERR_NONE);
            end
            default: begin
              res_q <= mk_res(ip_inc, 1'b0, '0, 1'b0, rame_pkg::ERR_NONE);
            end
          endcase
        end
        S_DIV: begin
          if (div_done) begin
            res_q   <= mk_res(ip_inc, 1'b0, '0, 1'b0, rame_pkg::ERR_NONE);
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            out_q       <= res_q;
            out_valid_q <= 1'b1;
            ip_q        <= res_q.ip;
            stopped_q   <= res_q.halted;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // instruction capture on acceptance
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      cmd_q  <= in_i.cmd;
      mode_q <= in_i.mode;
      arg_q  <= in_i.argument;
      rv_q   <= in_i.read_value;
    end
  end

  assign in_i.ready        = (state_q == S_IDLE);
  assign out_o.valid       = out_valid_q;
  assign out_o.next_ip     = out_q.ip;
  assign out_o.write_valid = out_q.wv;
  assign out_o.write_value = out_q.wval;
  assign out_o.halted      = out_q.halted;
  assign out_o.error_code  = out_q.err;

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("instruction accepted while previous still executing");

  a_error_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.error_code != rame_pkg::ERR_NONE)) |-> out_o.halted)
    else $error("error reported without halting");

  a_stop_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stopped_q |=> stopped_q)
    else $error("stopped machine restarted");

  a_write_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.write_valid) |->
      (!out_o.halted && (out_o.error_code == rame_pkg::ERR_NONE)))
    else $error("write value reported on a stopping instruction");
`endif

endmodule

`default_nettype wire

// ===== design/rame_div.sv =====
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none

module rame_div (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  rame_pkg::word_t dividend_i,
  input  rame_pkg::word_t divisor_i,
  output logic            done_o,
  output rame_pkg::word_t quotient_o
);

  localparam int unsigned W       = rame_pkg::WORD_BITS;
  localparam int unsigned CntBits = $clog2(W + 1);

  logic               busy_q;
  logic               done_q;
  logic [CntBits-1:0] cnt_q;
  logic               neg_q;
  rame_pkg::word_t    quo_q;
  rame_pkg::word_t    rem_q;
  rame_pkg::word_t    dvs_q;

  logic [W:0] shifted;
  logic [W:0] diff;
  logic       qbit;

  assign shifted = {rem_q, quo_q[W-1]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign qbit    = ~diff[W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntBits'(W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntBits'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath: magnitudes in, restoring steps, sign fixed on the way out
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[W-1] ^ divisor_i[W-1];
      quo_q <= dividend_i[W-1] ? rame_pkg::word_t'(~dividend_i + 1'b1) : dividend_i;
      dvs_q <= divisor_i[W-1] ? rame_pkg::word_t'(~divisor_i + 1'b1) : divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= qbit ? diff[W-1:0] : shifted[W-1:0];
      quo_q <= {quo_q[W-2:0], qbit};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? rame_pkg::word_t'(~quo_q + 1'b1) : quo_q;

endmodule

`default_nettype wire
